### sv/pva_pkg.sv
// Shared types, codes and constants for the voice allocator and envelope core.
// No dependencies; pva_env, pva_alloc and the core refer to it by scoped names.
`default_nettype none
package pva_pkg;

  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 2;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int STAGE_W     = 3;
  localparam int VOICE_OUT_W = 3;
  localparam int AGE_W       = 32;

  localparam int VOICES_DEF = 8;
  localparam int NOTES_DEF  = 128;
  localparam int LFB_DEF    = 23;

  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;
  localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd3;

  localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

  localparam logic [CFG_W-1:0] ATTACK_RST  = 24'd15797;
  localparam logic [CFG_W-1:0] DECAY_RST   = 24'd1313;
  localparam logic [CFG_W-1:0] SUSTAIN_RST = 24'd5872026;
  localparam logic [CFG_W-1:0] RELEASE_RST = 24'd1357;

  localparam logic [VEL_W-1:0] VEL_FULL = 7'd127;

  // Control from the sequencer to the allocation tracker
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage
`default_nettype wire

### sv/pva_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/pva_env.sv
// ADSR envelope step for one voice: next stage and clamped next level.
// Depends on pva_pkg for stage codes and register width.
`default_nettype none
module pva_env #(
  parameter int LFB = pva_pkg::LFB_DEF
) (
  input  wire logic [pva_pkg::STAGE_W-1:0] stage_cur,
  input  wire logic                        gate,
  input  wire logic [LFB:0]                level_cur,
  input  wire logic [pva_pkg::CFG_W-1:0]   attack_step,
  input  wire logic [pva_pkg::CFG_W-1:0]   decay_step,
  input  wire logic [pva_pkg::CFG_W-1:0]   sustain_level,
  input  wire logic [pva_pkg::CFG_W-1:0]   release_step,
  output logic      [pva_pkg::STAGE_W-1:0] stage_new,
  output logic      [LFB:0]                level_new,
  output logic                             silenced
);

  localparam int LW = LFB + 1;
  localparam int W  = (LW > pva_pkg::CFG_W ? LW : pva_pkg::CFG_W) + 1;

  logic [W-1:0] lvl;
  logic [W-1:0] full;
  logic [W-1:0] sus;
  logic [W-1:0] sus_raw;
  logic [W-1:0] atk;
  logic [W-1:0] dec;
  logic [W-1:0] rel;
  logic [W-1:0] res;

  assign lvl     = W'(level_cur);
  assign full    = W'(1) << LFB;
  assign sus_raw = W'(sustain_level);
  assign sus     = (sus_raw > full) ? full : sus_raw;
  assign atk     = W'(attack_step);
  assign dec     = W'(decay_step);
  assign rel     = W'(release_step);

  always_comb begin
    stage_new = stage_cur;
    res       = lvl;
    silenced  = 1'b0;
    case (stage_cur)
      pva_pkg::ST_ATTACK: begin
        if (lvl + atk >= full) begin
          res       = full;
          stage_new = gate ? pva_pkg::ST_DECAY : pva_pkg::ST_RELEASE;
        end else begin
          res = lvl + atk;
        end
      end
      pva_pkg::ST_DECAY: begin
        if (!gate) begin
          stage_new = pva_pkg::ST_RELEASE;
        end else if (lvl <= sus + dec) begin
          res       = sus;
          stage_new = pva_pkg::ST_SUSTAIN;
        end else begin
          res = lvl - dec;
        end
      end
      pva_pkg::ST_SUSTAIN: begin
        if (!gate) begin
          stage_new = pva_pkg::ST_RELEASE;
        end else begin
          res = sus;
        end
      end
      pva_pkg::ST_RELEASE: begin
        if (lvl <= rel) begin
          res       = '0;
          stage_new = pva_pkg::ST_IDLE;
          silenced  = 1'b1;
        end else begin
          res = lvl - rel;
        end
      end
      default: begin
        res = lvl;
      end
    endcase
  end

  assign level_new = LW'(res);

endmodule
`default_nettype wire

### sv/pva_alloc.sv
// Note-on voice choice: tracks matching, idle, quietest releasing and oldest
// voice while the table is scanned in index order. Depends on pva_pkg.
`default_nettype none
module pva_alloc #(
  parameter int VOICES = pva_pkg::VOICES_DEF,
  parameter int LFB    = pva_pkg::LFB_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pva_pkg::scan_ctl_t                ctl,
  input  wire logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] idx,
  input  wire logic [pva_pkg::STAGE_W-1:0]       stage,
  input  wire logic [pva_pkg::NOTE_W-1:0]        note_entry,
  input  wire logic [pva_pkg::NOTE_W-1:0]        note_req,
  input  wire logic [LFB:0]                      level,
  input  wire logic [pva_pkg::AGE_W-1:0]         age,
  output logic      [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] chosen
);

  localparam int VW = VOICES > 1 ? $clog2(VOICES) : 1;

  logic          match_found;
  logic          idle_found;
  logic          rel_found;
  logic [VW-1:0] match_idx;
  logic [VW-1:0] idle_idx;
  logic [VW-1:0] rel_idx;
  logic [VW-1:0] old_idx;
  logic [LFB:0]  rel_level;
  logic [pva_pkg::AGE_W-1:0] old_age;

  logic hit_match;
  logic hit_idle;
  logic hit_rel;
  logic hit_old;

  assign hit_match = !match_found && stage != pva_pkg::ST_IDLE && note_entry == note_req;
  assign hit_idle  = !idle_found && stage == pva_pkg::ST_IDLE;
  assign hit_rel   = stage == pva_pkg::ST_RELEASE && (!rel_found || level < rel_level);
  assign hit_old   = idx == '0 || age < old_age;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      match_found <= 1'b0;
      idle_found  <= 1'b0;
      rel_found   <= 1'b0;
    end else if (ctl.sample) begin
      if (hit_match) match_found <= 1'b1;
      if (hit_idle)  idle_found  <= 1'b1;
      if (hit_rel)   rel_found   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      if (hit_match) match_idx <= idx;
      if (hit_idle)  idle_idx  <= idx;
      if (hit_rel) begin
        rel_idx   <= idx;
        rel_level <= level;
      end
      if (hit_old) begin
        old_idx <= idx;
        old_age <= age;
      end
    end
  end

  assign chosen = match_found ? match_idx :
                  idle_found  ? idle_idx  :
                  rel_found   ? rel_idx   : old_idx;

endmodule
`default_nettype wire

### sv/polyphonic_voice_allocator_adsr_core.sv
// Polyphonic voice allocator with a per-voice ADSR envelope.
// Depends on pva_pkg, pva_ram, pva_env and pva_alloc.
//
// Usage:
//   Commands enter on start/operation/note/velocity and are taken on a clock
//   edge with start high and busy low. Each voice record lives in one RAM
//   entry; the sequencer walks the voices one per cycle through the read port
//   and, except on a note on, writes each entry back in the following cycle.
//   Sample tick: busy through the scan. Results leave on the result ports one
//   per cycle, in voice order, each marked by strobe for one cycle; last flags
//   the final voice. The receiver cannot stall: results are not held.
//   Note off / all notes off: busy through the scan, no results.
//   Note on: busy through the scan, a re-read of the chosen voice and its write
//   back, no results. A note on or off with an out-of-range note is taken and
//   dropped without the block going busy. The RAM port allows one read and one
//   write per cycle.
//   Reset: synchronous. Per-voice valid bits make unwritten entries read as
//   an idle, silent voice, so no clearing pass is needed; the block is ready
//   in the cycle after reset. Configuration writes take effect at the next
//   edge and must be made while the block is idle.
`default_nettype none
module polyphonic_voice_allocator_adsr_core #(
  parameter int VOICES              = pva_pkg::VOICES_DEF,
  parameter int NOTES               = pva_pkg::NOTES_DEF,
  parameter int LEVEL_FRACTION_BITS = pva_pkg::LFB_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [pva_pkg::OP_W-1:0]           operation,
  input  wire logic [pva_pkg::NOTE_W-1:0]         note,
  input  wire logic [pva_pkg::VEL_W-1:0]          velocity,
  input  wire logic                               cfg_write_en,
  input  wire logic [pva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pva_pkg::CFG_W-1:0]          cfg_data,
  output logic                                    strobe,
  output logic      [pva_pkg::VOICE_OUT_W-1:0]    voice,
  output logic                                    active,
  output logic      [pva_pkg::NOTE_W-1:0]         note_out,
  output logic      [pva_pkg::VEL_W-1:0]          velocity_out,
  output logic      [LEVEL_FRACTION_BITS:0]       level,
  output logic      [pva_pkg::STAGE_W-1:0]        stage,
  output logic                                    last
);

  localparam int VW = VOICES > 1 ? $clog2(VOICES) : 1;
  localparam int LW = LEVEL_FRACTION_BITS + 1;
  localparam int RW = pva_pkg::AGE_W + LW + 1 + pva_pkg::VEL_W + pva_pkg::NOTE_W
                      + pva_pkg::STAGE_W;
  localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);
  localparam logic [pva_pkg::NOTE_W:0] NOTE_LIM = (pva_pkg::NOTE_W + 1)'(NOTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ONRD  = 3'd3;
  localparam logic [2:0] S_ONWR  = 3'd4;

  // Configuration registers
  logic [pva_pkg::CFG_W-1:0] attack_step;
  logic [pva_pkg::CFG_W-1:0] decay_step;
  logic [pva_pkg::CFG_W-1:0] sustain_level;
  logic [pva_pkg::CFG_W-1:0] release_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= pva_pkg::ATTACK_RST;
      decay_step    <= pva_pkg::DECAY_RST;
      sustain_level <= pva_pkg::SUSTAIN_RST;
      release_step  <= pva_pkg::RELEASE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        pva_pkg::REG_ATTACK:  attack_step   <= cfg_data;
        pva_pkg::REG_DECAY:   decay_step    <= cfg_data;
        pva_pkg::REG_SUSTAIN: sustain_level <= cfg_data;
        pva_pkg::REG_RELEASE: release_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic [2:0]                       state;
  logic [2:0]                       state_next;
  logic [VW-1:0]                    cnt;
  logic                             p1_valid;
  logic [VW-1:0]                    p1_addr;
  logic [pva_pkg::OP_W-1:0]         op_q;
  logic [pva_pkg::NOTE_W-1:0]       note_q;
  logic [pva_pkg::VEL_W-1:0]        vel_q;
  logic [pva_pkg::AGE_W-1:0]        start_counter;
  logic [VOICES-1:0]                vld;

  logic accept;
  logic note_bad;
  assign busy     = state != S_IDLE;
  assign accept   = start && !busy;
  assign note_bad = {1'b0, note} >= NOTE_LIM;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !((operation == pva_pkg::OP_NOTE_ON ||
                         operation == pva_pkg::OP_NOTE_OFF) && note_bad)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN:  state_next = (cnt == LAST_V) ? S_DRAIN : S_SCAN;
      S_DRAIN: state_next = (op_q == pva_pkg::OP_NOTE_ON) ? S_ONRD : S_IDLE;
      S_ONRD:  state_next = S_ONWR;
      S_ONWR:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      p1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= state == S_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      note_q <= note;
      vel_q  <= velocity;
    end
    if (state == S_IDLE) begin
      cnt <= '0;
    end else if (state == S_SCAN) begin
      cnt <= cnt + VW'(1);
    end
    p1_addr <= cnt;
  end

  // Voice memory
  logic             we;
  logic [VW-1:0]    waddr;
  logic [VW-1:0]    raddr;
  logic [RW-1:0]    wdata;
  logic [RW-1:0]    rdata;
  logic [VW-1:0]    chosen;

  assign raddr = (state == S_SCAN) ? cnt : chosen;
  assign waddr = (state == S_ONWR) ? chosen : p1_addr;

  pva_ram #(
    .WIDTH (RW),
    .DEPTH (VOICES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Unpack the entry just read; an entry never written reads as an idle voice
  logic [RW-1:0]                 rec;
  logic [pva_pkg::AGE_W-1:0]     cur_age;
  logic [LW-1:0]                 cur_level;
  logic                          cur_gate;
  logic [pva_pkg::VEL_W-1:0]     cur_vel;
  logic [pva_pkg::NOTE_W-1:0]    cur_note;
  logic [pva_pkg::STAGE_W-1:0]   cur_stage;
  logic [VW-1:0]                 rec_addr;

  assign rec_addr = (state == S_ONWR) ? chosen : p1_addr;
  assign rec      = vld[rec_addr] ? rdata : '0;
  assign {cur_age, cur_level, cur_gate, cur_vel, cur_note, cur_stage} = rec;

  logic [pva_pkg::STAGE_W-1:0] env_stage;
  logic [LW-1:0]               env_level;
  logic                        env_silenced;

  pva_env #(
    .LFB (LEVEL_FRACTION_BITS)
  ) u_env (
    .stage_cur     (cur_stage),
    .gate          (cur_gate),
    .level_cur     (cur_level),
    .attack_step   (attack_step),
    .decay_step    (decay_step),
    .sustain_level (sustain_level),
    .release_step  (release_step),
    .stage_new     (env_stage),
    .level_new     (env_level),
    .silenced      (env_silenced)
  );

  pva_pkg::scan_ctl_t scan_ctl;
  assign scan_ctl.clear  = accept;
  assign scan_ctl.sample = p1_valid && op_q == pva_pkg::OP_NOTE_ON;

  pva_alloc #(
    .VOICES (VOICES),
    .LFB    (LEVEL_FRACTION_BITS)
  ) u_alloc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .idx        (p1_addr),
    .stage      (cur_stage),
    .note_entry (cur_note),
    .note_req   (note_q),
    .level      (cur_level),
    .age        (cur_age),
    .chosen     (chosen)
  );

  // Write-back
  logic                        is_tick;
  logic                        release_key;
  logic [pva_pkg::NOTE_W-1:0]  tick_note;
  logic                        tick_gate;
  logic [pva_pkg::AGE_W-1:0]   counter_inc;
  logic [pva_pkg::VEL_W-1:0]   vel_eff;

  assign is_tick     = op_q == pva_pkg::OP_TICK;
  assign release_key = cur_stage != pva_pkg::ST_IDLE &&
                       (op_q == pva_pkg::OP_ALL_OFF || cur_note == note_q);
  assign tick_note   = env_silenced ? '0 : cur_note;
  assign tick_gate   = env_silenced ? 1'b0 : cur_gate;
  assign counter_inc = start_counter + pva_pkg::AGE_W'(1);
  assign vel_eff     = (vel_q == '0) ? pva_pkg::VEL_FULL : vel_q;

  always_comb begin
    we    = 1'b0;
    wdata = rec;
    if (state == S_ONWR) begin
      we    = 1'b1;
      wdata = {counter_inc, cur_level, 1'b1, vel_eff, note_q, pva_pkg::ST_ATTACK};
    end else if (p1_valid && is_tick) begin
      we    = 1'b1;
      wdata = {cur_age, env_level, tick_gate, cur_vel, tick_note, env_stage};
    end else if (p1_valid && op_q != pva_pkg::OP_NOTE_ON) begin
      we    = 1'b1;
      wdata = {cur_age, cur_level, cur_gate && !release_key, cur_vel, cur_note, cur_stage};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      start_counter <= '0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      if (state == S_ONWR) start_counter <= counter_inc;
    end
  end

  // Result register: one transfer per voice on a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= p1_valid && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && is_tick) begin
      voice        <= pva_pkg::VOICE_OUT_W'(p1_addr);
      active       <= env_stage != pva_pkg::ST_IDLE;
      note_out     <= tick_note;
      velocity_out <= cur_vel;
      level        <= env_level;
      stage        <= env_stage;
      last         <= p1_addr == LAST_V;
    end
  end

  // Checks
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(we && (state == S_SCAN || state == S_ONRD) && raddr == waddr))
    else $error("read and write-back hit the same voice entry");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result transfer directly after final voice");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> level <= (LW'(1) << LEVEL_FRACTION_BITS))
    else $error("envelope level above full scale");

  a_active_stage: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (active == (stage != pva_pkg::ST_IDLE)) && (active || note_out == '0))
    else $error("active flag or note inconsistent with stage");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    accept && operation == pva_pkg::OP_TICK |=> busy && !strobe)
    else $error("tick did not start a scan");

endmodule
`default_nettype wire

### bench/voice_table_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the voice allocator bench: its own copy of the voice table and
// envelopes, and the queue of voice reports still due. Depends on pva_pkg.
package voice_table_check_pkg;
  import pva_pkg::*;

  localparam int     NV      = VOICES_DEF;
  localparam int     LEVEL_W = LFB_DEF + 1;
  localparam longint FULL    = longint'(1) << LFB_DEF;

  typedef struct packed {
    logic [VOICE_OUT_W-1:0] voice;
    logic                   active;
    logic [NOTE_W-1:0]      note;
    logic [VEL_W-1:0]       vel;
    logic [LEVEL_W-1:0]     level;
    logic [STAGE_W-1:0]     stage;
    logic                   last;
  } voice_report_t;

  class voice_table_scoreboard;
    logic [CFG_W-1:0]   attack_step;
    logic [CFG_W-1:0]   decay_step;
    logic [CFG_W-1:0]   sustain_level;
    logic [CFG_W-1:0]   release_step;
    logic [STAGE_W-1:0] v_stage [NV];
    logic [NOTE_W-1:0]  v_note [NV];
    logic [VEL_W-1:0]   v_vel [NV];
    logic               v_gate [NV];
    longint             v_level [NV];
    logic [AGE_W-1:0]   v_age [NV];
    logic [AGE_W-1:0]   start_count;
    voice_report_t      pending_reports [$];
    int                 errors;

    function new();
      attack_step   = ATTACK_RST;
      decay_step    = DECAY_RST;
      sustain_level = SUSTAIN_RST;
      release_step  = RELEASE_RST;
      for (int v = 0; v < NV; v++) begin
        v_stage[v] = ST_IDLE;
        v_note[v]  = '0;
        v_vel[v]   = '0;
        v_gate[v]  = 1'b0;
        v_level[v] = 0;
        v_age[v]   = '0;
      end
      start_count = '0;
      errors      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ATTACK:  attack_step   = data;
        REG_DECAY:   decay_step    = data;
        REG_SUSTAIN: sustain_level = data;
        REG_RELEASE: release_step  = data;
        default: ;
      endcase
    endfunction

    // Same note first, then lowest idle, then quietest releasing, then oldest.
    function int choose_voice(logic [NOTE_W-1:0] n);
      int  best;
      bit  found;
      best  = 0;
      found = 1'b0;
      for (int v = 0; v < NV; v++)
        if (v_stage[v] != ST_IDLE && v_note[v] == n) return v;
      for (int v = 0; v < NV; v++)
        if (v_stage[v] == ST_IDLE) return v;
      for (int v = 0; v < NV; v++) begin
        if (v_stage[v] == ST_RELEASE && (!found || v_level[v] < v_level[best])) begin
          best  = v;
          found = 1'b1;
        end
      end
      if (found) return best;
      best = 0;
      for (int v = 1; v < NV; v++)
        if (v_age[v] < v_age[best]) best = v;
      return best;
    endfunction

    function void step_envelope(int v);
      longint lvl;
      longint sus;
      lvl = v_level[v];
      sus = (longint'(sustain_level) > FULL) ? FULL : longint'(sustain_level);
      case (v_stage[v])
        ST_ATTACK: begin
          lvl = lvl + longint'(attack_step);
          if (lvl >= FULL) begin
            lvl        = FULL;
            v_stage[v] = v_gate[v] ? ST_DECAY : ST_RELEASE;
          end
        end
        ST_DECAY: begin
          if (!v_gate[v]) begin
            v_stage[v] = ST_RELEASE;
          end else begin
            lvl = lvl - longint'(decay_step);
            if (lvl <= sus) begin
              lvl        = sus;
              v_stage[v] = ST_SUSTAIN;
            end
          end
        end
        ST_SUSTAIN: begin
          if (!v_gate[v]) v_stage[v] = ST_RELEASE;
          else lvl = sus;
        end
        ST_RELEASE: begin
          lvl = lvl - longint'(release_step);
          if (lvl <= 0) begin
            lvl        = 0;
            v_stage[v] = ST_IDLE;
            v_note[v]  = '0;
            v_gate[v]  = 1'b0;
          end
        end
        default: ;
      endcase
      v_level[v] = lvl;
    endfunction

    function void note_transfer(logic [OP_W-1:0] op, logic [NOTE_W-1:0] n,
                                logic [VEL_W-1:0] vel);
      int            v;
      voice_report_t rep;
      case (op)
        OP_NOTE_ON: begin
          v          = choose_voice(n);
          v_note[v]  = n;
          v_vel[v]   = (vel == '0) ? VEL_FULL : vel;
          v_gate[v]  = 1'b1;
          v_stage[v] = ST_ATTACK;
          start_count = start_count + 1;
          v_age[v]   = start_count;
        end
        OP_NOTE_OFF: begin
          for (int i = 0; i < NV; i++)
            if (v_stage[i] != ST_IDLE && v_note[i] == n) v_gate[i] = 1'b0;
        end
        OP_ALL_OFF: begin
          for (int i = 0; i < NV; i++)
            if (v_stage[i] != ST_IDLE) v_gate[i] = 1'b0;
        end
        default: begin
          for (int i = 0; i < NV; i++) begin
            step_envelope(i);
            rep.voice  = VOICE_OUT_W'(i);
            rep.active = (v_stage[i] != ST_IDLE);
            rep.note   = v_note[i];
            rep.vel    = v_vel[i];
            rep.level  = LEVEL_W'(v_level[i]);
            rep.stage  = v_stage[i];
            rep.last   = (i == NV - 1);
            pending_reports.push_back(rep);
          end
        end
      endcase
    endfunction

    function void check_report(voice_report_t got);
      voice_report_t exp;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected voice report: voice %0d level %0d stage %0d",
                   got.voice, got.level, got.stage);
        return;
      end
      exp = pending_reports.pop_front();
      if (got.voice !== exp.voice || got.active !== exp.active ||
          got.note !== exp.note || got.vel !== exp.vel || got.level !== exp.level ||
          got.stage !== exp.stage || got.last !== exp.last) begin
        errors++;
        if (errors <= 10) begin
          $display("voice report mismatch (voice/active/note/vel/level/stage/last)");
          $display("  expected %0d/%0b/%0d/%0d/%0d/%0d/%0b", exp.voice, exp.active,
                   exp.note, exp.vel, exp.level, exp.stage, exp.last);
          $display("  actual   %0d/%0b/%0d/%0d/%0d/%0d/%0b", got.voice, got.active,
                   got.note, got.vel, got.level, got.stage, got.last);
        end
      end
    endfunction
  endclass

endpackage

### bench/tb_polyphonic_voice_allocator_adsr_core.sv
`timescale 1ns / 1ps
// Top-level bench for the voice allocator and envelope core: drives commands and
// register writes, checks every voice report. Depends on pva_pkg and voice_table_check_pkg.
module tb_polyphonic_voice_allocator_adsr_core;
  import pva_pkg::*;
  import voice_table_check_pkg::*;

  localparam int               CYCLE_LIMIT = 200000;
  localparam logic [CFG_W-1:0] FULL_LEVEL  = CFG_W'(1) << LFB_DEF;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   start        = 1'b0;
  logic [OP_W-1:0]        operation    = OP_TICK;
  logic [NOTE_W-1:0]      note         = '0;
  logic [VEL_W-1:0]       velocity     = '0;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index    = REG_ATTACK;
  logic [CFG_W-1:0]       cfg_data     = '0;
  logic                   busy;
  logic                   strobe;
  logic [VOICE_OUT_W-1:0] voice;
  logic                   active;
  logic [NOTE_W-1:0]      note_out;
  logic [VEL_W-1:0]       velocity_out;
  logic [LFB_DEF:0]       level;
  logic [STAGE_W-1:0]     stage;
  logic                   last;

  voice_table_scoreboard sb;
  int unsigned           cycles  = 0;
  bit                    gaps_on = 1'b1;

  always #5 clk = ~clk;

  polyphonic_voice_allocator_adsr_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .note         (note),
    .velocity     (velocity),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .voice        (voice),
    .active       (active),
    .note_out     (note_out),
    .velocity_out (velocity_out),
    .level        (level),
    .stage        (stage),
    .last         (last)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_report({voice, active, note_out, velocity_out, level, stage, last});
      if (cfg_write_en) sb.write_register(cfg_index, cfg_data);
      if (start && !busy) sb.note_transfer(operation, note, velocity);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [6:0] any_7bit();
    return 7'($urandom_range(0, 127));
  endfunction

  // Now and then drop start for a short burst, with junk on the command fields.
  task automatic maybe_gap();
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n         = $urandom_range(1, 5);
      start     = 1'b0;
      operation = OP_W'($urandom_range(0, 3));
      note      = any_7bit();
      velocity  = any_7bit();
      repeat (n) @(negedge clk);
    end
  endtask

  // Present one command and hold it until the transfer.
  task automatic issue(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] n,
                       input logic [VEL_W-1:0] vel);
    maybe_gap();
    start     = 1'b1;
    operation = op;
    note      = n;
    velocity  = vel;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold off until all reports are in and any note command has finished.
  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (VOICES_DEF + 4) @(negedge clk);
  endtask

  task automatic set_envelope(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] d,
                              input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] vals [4];
    vals = '{a, d, s, r};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_write_en = 1'b1;
      cfg_index    = CFG_IDX_W'(i);
      cfg_data     = vals[i];
      @(negedge clk);
    end
    cfg_write_en = 1'b0;
  endtask

  // Mostly notes from a narrow range so that offs and retriggers hit live voices.
  task automatic random_items(input int count);
    int               done;
    int               pick;
    int               base;
    logic [NOTE_W-1:0] n;
    base = $urandom_range(0, 116);
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) n = any_7bit();
      else n = NOTE_W'(base + $urandom_range(0, 11));
      if (pick < 4) begin
        // full chord: forces a steal
        for (int i = 0; i <= VOICES_DEF; i++)
          issue(OP_NOTE_ON, NOTE_W'(base + i), any_7bit());
        done += VOICES_DEF + 1;
      end else begin
        if (pick < 42) issue(OP_TICK, any_7bit(), any_7bit());
        else if (pick < 72) issue(OP_NOTE_ON, n, any_7bit());
        else if (pick < 94) issue(OP_NOTE_OFF, n, any_7bit());
        else issue(OP_ALL_OFF, any_7bit(), any_7bit());
        done++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // reset register values: field extremes, retrigger, silent note off, oldest steal
    issue(OP_TICK, 7'd127, 7'd127);
    issue(OP_NOTE_ON, 7'd0, 7'd0);
    issue(OP_TICK, 7'd0, 7'd0);
    issue(OP_NOTE_ON, 7'd127, 7'd127);
    issue(OP_NOTE_ON, 7'd60, 7'd1);
    issue(OP_NOTE_ON, 7'd60, 7'd64);
    issue(OP_NOTE_OFF, 7'd5, 7'd0);
    for (int i = 61; i <= 65; i++) issue(OP_NOTE_ON, NOTE_W'(i), VEL_W'(i));
    issue(OP_NOTE_ON, 7'd70, 7'd9);
    issue(OP_ALL_OFF, 7'd0, 7'd0);
    issue(OP_TICK, 7'd0, 7'd0);
    random_items(25);

    // fast envelope: releases at equal levels, so steals tie on the lowest voice
    set_envelope(FULL_LEVEL, FULL_LEVEL, FULL_LEVEL / 2, FULL_LEVEL / 4);
    for (int i = 20; i < 20 + VOICES_DEF; i++) issue(OP_NOTE_ON, NOTE_W'(i), 7'd100);
    issue(OP_TICK, 7'd0, 7'd0);
    issue(OP_ALL_OFF, 7'd0, 7'd0);
    issue(OP_TICK, 7'd0, 7'd0);
    issue(OP_TICK, 7'd0, 7'd0);
    issue(OP_NOTE_ON, 7'd30, 7'd50);
    random_items(20);

    set_envelope(FULL_LEVEL, FULL_LEVEL, '0, FULL_LEVEL);
    random_items(25);
    set_envelope(CFG_W'(1), CFG_W'(1), FULL_LEVEL, CFG_W'(1));
    random_items(20);
    // zero attack and release steps stall their stage; sustain above full clamps
    set_envelope('0, '0, '1, '0);
    random_items(20);
    set_envelope(CFG_W'($urandom_range(150000, 3000000)),
                 CFG_W'($urandom_range(150000, 3000000)),
                 CFG_W'($urandom_range(0, 8388608)),
                 CFG_W'($urandom_range(150000, 3000000)));
    random_items(35);
    set_envelope(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    random_items(25);

    gaps_on = 1'b0;
    set_envelope(CFG_W'($urandom_range(300000, 4000000)),
                 CFG_W'($urandom_range(300000, 4000000)),
                 CFG_W'($urandom_range(0, 8388608)),
                 CFG_W'($urandom_range(300000, 4000000)));
    random_items(30);

    wait_idle();
    repeat (20) @(negedge clk);
    if (sb.pending_reports.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/pva_pkg.sv
sv/pva_ram.sv
sv/pva_env.sv
sv/pva_alloc.sv
sv/polyphonic_voice_allocator_adsr_core.sv
bench/voice_table_check_pkg.sv
bench/tb_polyphonic_voice_allocator_adsr_core.sv
